[rtl/linked_index_merge_sorter_defines.svh]
// ----------------------------------------------------------------------------
// Linked index merge sorter assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef LINKED_INDEX_MERGE_SORTER_DEFINES_SVH
`define LINKED_INDEX_MERGE_SORTER_DEFINES_SVH

// same-cycle implication
`define LIMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LIMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lims_pkg.sv]
// ----------------------------------------------------------------------------
// Linked index merge sorter package
// Field widths, buffer entry and inter-module control structs, sequencer states.
// ----------------------------------------------------------------------------
package lims_pkg;

  localparam int KEY_W         = 32;
  localparam int IDX_W         = 6;
  localparam int MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [KEY_W-1:0] key;
  } lims_entry_t;

  typedef struct packed {
    logic        wr;
    logic        start;
    logic [IDX_W:0] count;
    lims_entry_t entry;
  } lims_load_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    lims_entry_t entry;
  } lims_emit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN_INIT,
    ST_FILL_A,
    ST_FILL_B,
    ST_MERGE,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_EMIT
  } lims_state_t;

endpackage

[rtl/lims_if.sv]
// ----------------------------------------------------------------------------
// Linked index merge sorter channels
// Valid/ready channels for loaded keys and for sorted results.
// ----------------------------------------------------------------------------
interface lims_item_if;
  logic                              valid;
  logic                              ready;
  logic signed [lims_pkg::KEY_W-1:0] key;
  logic                              is_last;

  modport source (output valid, output key, output is_last, input ready);
  modport sink   (input valid, input key, input is_last, output ready);
endinterface

interface lims_result_if;
  logic                              valid;
  logic                              ready;
  logic [lims_pkg::IDX_W-1:0]        orig_index;
  logic signed [lims_pkg::KEY_W-1:0] sorted_key;
  logic                              last_out;
  logic                              overflow;

  modport source (output valid, output orig_index, output sorted_key, output last_out,
                  output overflow, input ready);
  modport sink   (input valid, input orig_index, input sorted_key, input last_out,
                  input overflow, output ready);
endinterface

[rtl/lims_cmp.sv]
// ----------------------------------------------------------------------------
// Linked index merge sorter key comparator
// Shared signed compare of the two run heads; picks the right head only when
// its key is strictly smaller, which keeps equal keys in load order.
// ----------------------------------------------------------------------------
module lims_cmp (
  input  lims_pkg::lims_entry_t a,
  input  lims_pkg::lims_entry_t b,
  output logic                  b_first
);

  assign b_first = $signed(a.key) > $signed(b.key);

endmodule

[rtl/lims_engine.sv]
// ----------------------------------------------------------------------------
// Linked index merge sorter engine
// Ping-pong entry buffers, bottom-up merge sequencer around one comparator,
// and sequential read-out of the sorted buffer.
// ----------------------------------------------------------------------------
`include "linked_index_merge_sorter_defines.svh"

module lims_engine #(
  parameter int MAX_ITEMS = lims_pkg::MAX_ITEMS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lims_pkg::lims_load_t load,
  output logic                 idle,
  output lims_pkg::lims_emit_t emit,
  input  logic                 emit_ready
);

  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int SW    = CW + 2;
  localparam int DEPTH = MAX_ITEMS;

  lims_pkg::lims_entry_t mem_a [DEPTH];
  lims_pkg::lims_entry_t mem_b [DEPTH];
  lims_pkg::lims_entry_t rd_a, rd_b, rd;
  lims_pkg::lims_entry_t ha, ha_next, hb, hb_next, wr_data, a_data;

  lims_pkg::lims_state_t st, st_next;
  logic          sel, sel_next;
  logic [CW-1:0] n, n_next, w, w_next, lo, lo_next;
  logic [CW-1:0] mid, mid_next, hi, hi_next;
  logic [CW-1:0] i, i_next, j, j_next, k, k_next, e, e_next;
  logic [CW-1:0] i_inc, j_inc, k_inc, e_inc;
  logic [SW-1:0] lo_w, w_2, lo_2w;
  logic [AW-1:0] rd_addr, a_addr;
  logic          wr_en, a_we, b_we;
  logic          b_first, a_ok, b_ok, take_b;

  lims_cmp u_cmp (
    .a       (ha),
    .b       (hb),
    .b_first (b_first)
  );

  assign rd = sel ? rd_b : rd_a;

  always_comb begin
    lo_w  = SW'(lo) + SW'(w);
    w_2   = SW'(w) << 1;
    lo_2w = SW'(lo) + w_2;
    i_inc = i + 1'b1;
    j_inc = j + 1'b1;
    k_inc = k + 1'b1;
    e_inc = e + 1'b1;
    a_ok   = i < mid;
    b_ok   = j < hi;
    take_b = b_ok && (!a_ok || b_first);

    st_next  = st;
    sel_next = sel;
    n_next   = n;
    w_next   = w;
    lo_next  = lo;
    mid_next = mid;
    hi_next  = hi;
    i_next   = i;
    j_next   = j;
    k_next   = k;
    e_next   = e;
    ha_next  = ha;
    hb_next  = hb;
    rd_addr  = i[AW-1:0];
    wr_en    = 1'b0;
    wr_data  = ha;
    idle     = (st == lims_pkg::ST_IDLE);
    emit.valid = 1'b0;
    emit.last  = (e_inc == n);
    emit.entry = rd;

    case (st)
      lims_pkg::ST_IDLE: begin
        if (load.start) begin
          n_next   = load.count[CW-1:0];
          w_next   = CW'(1);
          lo_next  = '0;
          sel_next = 1'b0;
          st_next  = lims_pkg::ST_RUN_INIT;
        end
      end
      lims_pkg::ST_RUN_INIT: begin
        mid_next = (lo_w < SW'(n)) ? lo_w[CW-1:0] : n;
        hi_next  = (lo_2w < SW'(n)) ? lo_2w[CW-1:0] : n;
        i_next   = lo;
        j_next   = mid_next;
        k_next   = lo;
        rd_addr  = lo[AW-1:0];
        st_next  = lims_pkg::ST_FILL_A;
      end
      lims_pkg::ST_FILL_A: begin
        ha_next = rd;
        if (b_ok) begin
          rd_addr = j[AW-1:0];
          st_next = lims_pkg::ST_FILL_B;
        end else begin
          st_next = lims_pkg::ST_MERGE;
        end
      end
      lims_pkg::ST_FILL_B: begin
        hb_next = rd;
        st_next = lims_pkg::ST_MERGE;
      end
      lims_pkg::ST_MERGE: begin
        if (take_b) begin
          wr_en   = 1'b1;
          wr_data = hb;
          j_next  = j_inc;
          k_next  = k_inc;
          if (j_inc < hi) begin
            rd_addr = j_inc[AW-1:0];
            st_next = lims_pkg::ST_LOAD_B;
          end
        end else if (a_ok) begin
          wr_en   = 1'b1;
          wr_data = ha;
          i_next  = i_inc;
          k_next  = k_inc;
          if (i_inc < mid) begin
            rd_addr = i_inc[AW-1:0];
            st_next = lims_pkg::ST_LOAD_A;
          end
        end else if (lo_2w < SW'(n)) begin
          lo_next = lo_2w[CW-1:0];
          st_next = lims_pkg::ST_RUN_INIT;
        end else begin
          sel_next = !sel;
          if (w_2 < SW'(n)) begin
            w_next  = w_2[CW-1:0];
            lo_next = '0;
            st_next = lims_pkg::ST_RUN_INIT;
          end else begin
            e_next  = '0;
            rd_addr = '0;
            st_next = lims_pkg::ST_EMIT;
          end
        end
      end
      lims_pkg::ST_LOAD_A: begin
        ha_next = rd;
        st_next = lims_pkg::ST_MERGE;
      end
      lims_pkg::ST_LOAD_B: begin
        hb_next = rd;
        st_next = lims_pkg::ST_MERGE;
      end
      lims_pkg::ST_EMIT: begin
        emit.valid = 1'b1;
        rd_addr    = e[AW-1:0];
        if (emit_ready) begin
          if (emit.last) begin
            sel_next = 1'b0;
            st_next  = lims_pkg::ST_IDLE;
          end else begin
            e_next  = e_inc;
            rd_addr = e_inc[AW-1:0];
          end
        end
      end
      default: begin
        st_next = lims_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= lims_pkg::ST_IDLE;
      sel <= 1'b0;
    end else begin
      st  <= st_next;
      sel <= sel_next;
    end
  end

  always_ff @(posedge clk) begin
    n   <= n_next;
    w   <= w_next;
    lo  <= lo_next;
    mid <= mid_next;
    hi  <= hi_next;
    i   <= i_next;
    j   <= j_next;
    k   <= k_next;
    e   <= e_next;
    ha  <= ha_next;
    hb  <= hb_next;
  end

  assign a_we   = load.wr || (wr_en && sel);
  assign a_addr = load.wr ? load.entry.idx[AW-1:0] : k[AW-1:0];
  assign a_data = load.wr ? load.entry : wr_data;
  assign b_we   = wr_en && !sel;

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[a_addr] <= a_data;
    end
    rd_a <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      mem_b[k[AW-1:0]] <= wr_data;
    end
    rd_b <= mem_b[rd_addr];
  end

  `LIMS_ASSERT_IMP(a_idle_sel, st == lims_pkg::ST_IDLE, !sel, "buffer select set while idle")
  `LIMS_ASSERT_IMP(a_run_full, st == lims_pkg::ST_MERGE && !a_ok && !b_ok, k == hi, "run closed with slots unwritten")
  `LIMS_ASSERT_IMP(a_emit_range, emit.valid, e < n, "read-out index beyond element count")

endmodule

[rtl/linked_index_merge_sorter.sv]
// ----------------------------------------------------------------------------
// Linked index merge sorter
// Loads signed keys tagged with their load position, stable merge sorts them
// on the last key and returns them in ascending order.
// ----------------------------------------------------------------------------
// channel | dir | payload                                     | transaction
// item    | in  | key, is_last                                | one key to load
// result  | out | orig_index, sorted_key, last_out, overflow  | one sorted element
//
// Loading stores each accepted key at its load position; keys past MAX_ITEMS are dropped.
// Sorting n keys takes max(1, ceil(log2 n)) passes of the shared comparator and
// item.ready is low meanwhile. Read-out gives one result per cycle through the
// output register while the result channel is not stalled by result.ready.
// rst is synchronous; the entry buffers need no clearing pass.
// ----------------------------------------------------------------------------
`include "linked_index_merge_sorter_defines.svh"

module linked_index_merge_sorter #(
  parameter int MAX_ITEMS = lims_pkg::MAX_ITEMS_DEF
) (
  input logic           clk,
  input logic           rst,
  lims_item_if.sink     item,
  lims_result_if.source result
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0]        load_count;
  logic                 overflow_seen;
  logic                 idle, accept, full, emit_ready, take_emit;
  lims_pkg::lims_load_t load;
  lims_pkg::lims_emit_t emit;

  assign item.ready = idle;
  assign accept     = item.valid && item.ready;
  assign full       = (load_count == CW'(MAX_ITEMS));
  assign emit_ready = !result.valid || result.ready;
  assign take_emit  = emit.valid && emit_ready;

  always_comb begin
    load.wr        = accept && !full;
    load.start     = accept && item.is_last;
    load.count     = full ? (lims_pkg::IDX_W + 1)'(MAX_ITEMS)
                          : (lims_pkg::IDX_W + 1)'(load_count + 1'b1);
    load.entry.idx = lims_pkg::IDX_W'(load_count);
    load.entry.key = item.key;
  end

  lims_engine #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .idle       (idle),
    .emit       (emit),
    .emit_ready (emit_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count    <= '0;
      overflow_seen <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      if (take_emit && emit.last) begin
        load_count    <= '0;
        overflow_seen <= 1'b0;
      end else if (accept) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          load_count <= load_count + 1'b1;
        end
      end
      if (take_emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_emit) begin
      result.orig_index <= emit.entry.idx;
      result.sorted_key <= emit.entry.key;
      result.last_out   <= emit.last;
      result.overflow   <= overflow_seen;
    end
  end

  `LIMS_ASSERT_IMP(a_count_bound, 1'b1, load_count <= CW'(MAX_ITEMS),
                   "load count beyond capacity")
  `LIMS_ASSERT_NEXT(a_run_clear, take_emit && emit.last,
                    load_count == '0 && !overflow_seen, "loader not cleared after run")

endmodule
